### rtl/core/absd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd_pkg
// Shared types, codes and tables for the audio byte sample decoder.
// ----------------------------------------------------------------------------
package absd_pkg;

  // configuration register map (word index)
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam logic [0:0]  REG_CODEC_MODE    = 1'b0;

  // codec_mode register codes
  localparam logic [1:0] MODE_PCM8   = 2'd0;
  localparam logic [1:0] MODE_PDM1   = 2'd1;
  localparam logic [1:0] MODE_ADPCM4 = 2'd2;

  localparam logic [6:0] STEP_MAX = 7'd88;

  typedef enum logic [1:0] {
    KIND_PCM,
    KIND_PDM,
    KIND_ADPCM
  } absd_kind_t;

  // one classified word waiting for the back end
  typedef struct packed {
    absd_kind_t  kind;
    logic [7:0]  data;
    logic        restart;
  } absd_entry_t;

  // IMA step table; position 88 and beyond read 32767
  function automatic logic [14:0] step_lookup(input logic [6:0] pos);
    logic [14:0] s;
    unique case (pos)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // step index adaptation from the three magnitude bits
  function automatic logic signed [4:0] adapt_lookup(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/audio_byte_sample_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_byte_sample_decoder
// Turns encoded audio bytes into duty levels for PCM8, PDM1 or IMA ADPCM4.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  APB-style port; codec_mode sits at byte address 0 (bits 1:0).
//          Write it only while the decoder is idle.
//   in_*   valid/ready; one encoded byte per word plus a restart flag that
//          clears the ADPCM predictor and step index before the byte.
//   out_*  valid/ready; one level per word, out_last marks the final
//          level of each input byte.
// Throughput: one sample per cycle while out_ready holds; PCM8 gives
//   one sample per byte, ADPCM4 two and PDM1 eight.
// The first output word of a byte passes the queue write, then the
//   output register.
// A two-entry queue separates acceptance from decoding, so input keeps
// flowing while an output word waits; a stalled receiver holds the back
// end and, once the queue fills, in_ready drops.
// Reset clears codec_mode to PCM8, the predictor and step index to zero,
// and empties the queue and output register.
// ----------------------------------------------------------------------------
module audio_byte_sample_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [absd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [absd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [absd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_level,
  output logic                             out_last
);

  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_valid;
  absd_pkg::absd_entry_t q_wr_entry;
  absd_pkg::absd_entry_t q_rd_entry;

  absd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .in_restart  (in_restart),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wr_entry  (q_wr_entry)
  );

  absd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_entry(q_wr_entry),
    .full    (q_full),
    .pop     (q_pop),
    .rd_valid(q_valid),
    .rd_entry(q_rd_entry)
  );

  absd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_level(out_level),
    .out_last (out_last)
  );

endmodule

### rtl/core/absd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd_front
// Holds the codec_mode register, accepts input words and tags each with
// the codec that will decode it before it enters the queue.
// ----------------------------------------------------------------------------
module absd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [absd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [absd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [absd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_restart,
  input  logic                                q_full,
  output logic                                q_push,
  output absd_pkg::absd_entry_t               q_wr_entry
);

  localparam int unsigned CFG_ADDR_HI = absd_pkg::CFG_ADDR_W - 1;

  logic [1:0]           codec_mode_r;
  logic [1:0]           codec_mode_nxt;
  logic                 reg_sel;
  absd_pkg::absd_kind_t kind;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_HI:2] == absd_pkg::REG_CODEC_MODE);

  always_comb begin
    codec_mode_nxt = codec_mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      codec_mode_nxt = cfg_pwdata[1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel) begin
      cfg_prdata = {{(absd_pkg::CFG_DATA_W-2){1'b0}}, codec_mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= absd_pkg::MODE_PCM8;
    end else begin
      codec_mode_r <= codec_mode_nxt;
    end
  end

  // unused mode code decodes as PDM
  always_comb begin
    unique case (codec_mode_r)
      absd_pkg::MODE_PCM8:   kind = absd_pkg::KIND_PCM;
      absd_pkg::MODE_ADPCM4: kind = absd_pkg::KIND_ADPCM;
      default:               kind = absd_pkg::KIND_PDM;
    endcase
  end

  assign in_ready           = ~q_full;
  assign q_push             = in_valid & ~q_full;
  assign q_wr_entry.kind    = kind;
  assign q_wr_entry.data    = in_data_byte;
  assign q_wr_entry.restart = in_restart;

endmodule

### rtl/core/absd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd_queue
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module absd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  absd_pkg::absd_entry_t  wr_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   rd_valid,
  output absd_pkg::absd_entry_t  rd_entry
);

  absd_pkg::absd_entry_t slot_r [2];
  logic                  wr_ptr_r;
  logic                  wr_ptr_nxt;
  logic                  rd_ptr_r;
  logic                  rd_ptr_nxt;
  logic [1:0]            count_r;
  logic [1:0]            count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

### rtl/core/absd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absd_back
// Expands each queued word into its samples, one per cycle unless the
// output stalls, runs the ADPCM predictor and drives the registered output.
// ----------------------------------------------------------------------------
module absd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  absd_pkg::absd_entry_t  q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_level,
  output logic                   out_last
);

  logic                  busy_r, busy_nxt;
  absd_pkg::absd_entry_t entry_r, entry_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic signed [15:0]    pred_r, pred_nxt;
  logic [6:0]            pos_r, pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_level_r, out_level_nxt;
  logic                  out_last_r, out_last_nxt;

  absd_pkg::absd_entry_t cur;
  logic                  cur_valid;
  logic [2:0]            cur_cnt;
  logic                  adv;
  logic                  fire;
  logic                  clr;
  logic signed [15:0]    pred_eff;
  logic [6:0]            pos_eff;
  logic [3:0]            nib;
  logic [14:0]           step;
  logic [16:0]           diff;
  logic signed [17:0]    sum;
  logic signed [15:0]    pred_sat;
  logic signed [8:0]     pos_sum;
  logic [6:0]            pos_new;
  logic                  is_last;
  logic [7:0]            level;

  always_comb begin
    cur       = busy_r ? entry_r : q_entry;
    cur_valid = busy_r | q_valid;
    cur_cnt   = busy_r ? cnt_r : 3'd0;
    adv       = ~out_valid_r | out_ready;
    fire      = adv & cur_valid;
    clr       = cur.restart & ~busy_r;
    pred_eff  = clr ? 16'sd0 : pred_r;
    pos_eff   = clr ? 7'd0 : pos_r;
  end

  // one ADPCM nibble: low nibble first, then high
  always_comb begin
    nib  = cur_cnt[0] ? cur.data[7:4] : cur.data[3:0];
    step = absd_pkg::step_lookup(pos_eff);
    diff = 17'(step >> 3)
         + (nib[0] ? 17'(step >> 2) : 17'd0)
         + (nib[1] ? 17'(step >> 1) : 17'd0)
         + (nib[2] ? 17'(step)      : 17'd0);
    if (nib[3]) begin
      sum = 18'(pred_eff) - $signed({1'b0, diff});
    end else begin
      sum = 18'(pred_eff) + $signed({1'b0, diff});
    end
    if (sum > 18'sd32767) begin
      pred_sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      pred_sat = 16'sh8000;
    end else begin
      pred_sat = sum[15:0];
    end
    pos_sum = $signed({2'b00, pos_eff}) + 9'(absd_pkg::adapt_lookup(nib[2:0]));
    if (pos_sum < 9'sd0) begin
      pos_new = 7'd0;
    end else if (pos_sum > $signed({2'b00, absd_pkg::STEP_MAX})) begin
      pos_new = absd_pkg::STEP_MAX;
    end else begin
      pos_new = pos_sum[6:0];
    end
  end

  always_comb begin
    unique case (cur.kind)
      absd_pkg::KIND_PCM: begin
        is_last = 1'b1;
        level   = cur.data;
      end
      absd_pkg::KIND_ADPCM: begin
        is_last = (cur_cnt == 3'd1);
        // (p + 32768) >> 8
        level   = {~pred_sat[15], pred_sat[14:8]};
      end
      default: begin
        is_last = (cur_cnt == 3'd7);
        level   = {7'd0, cur.data[~cur_cnt]};
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    entry_nxt     = entry_r;
    cnt_nxt       = cnt_r;
    pred_nxt      = pred_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_last_nxt  = out_last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = level;
      out_last_nxt  = is_last;
      busy_nxt      = ~is_last;
      entry_nxt     = cur;
      cnt_nxt       = cur_cnt + 3'd1;
      pred_nxt      = pred_eff;
      pos_nxt       = pos_eff;
      if (cur.kind == absd_pkg::KIND_ADPCM) begin
        pred_nxt = pred_sat;
        pos_nxt  = pos_new;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign q_pop     = fire & ~busy_r;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pred_r      <= 16'sd0;
      pos_r       <= 7'd0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pred_r      <= pred_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r     <= entry_nxt;
    cnt_r       <= cnt_nxt;
    out_level_r <= out_level_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= absd_pkg::STEP_MAX)
    else $error("step index left the table");

  a_pcm_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (entry_r.kind != absd_pkg::KIND_PCM))
    else $error("PCM word held over more than one cycle");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !adv) |=> (busy_r && $stable(cnt_r) && $stable(pred_r)))
    else $error("sample position moved during output stall");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("queue popped while a word is still expanding");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last) |=> !busy_r)
    else $error("word still busy after its final sample");

endmodule
